/* rtl/core/ttcr_pkg.sv */
package ttcr_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths
  localparam int CFG_W   = 7;   // tiles_x, tiles_y, blocks_x, blocks_y
  localparam int COORD_W = 16;  // coord_u, coord_v, atlas_u, atlas_v
  localparam int BLOCK_W = 12;  // entry_block, block_number
  localparam int INDEX_W = 12;  // entry_index
  localparam int CELL_W  = 14;  // largest cell index: 126 * 127 + 126
  localparam int LIMIT_W = 17;  // holds any table depth up to 65536
  localparam int REG_IDX_W = 2;

  // Register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TILES_X  = 2'd0,
    REG_TILES_Y  = 2'd1,
    REG_BLOCKS_X = 2'd2,
    REG_BLOCKS_Y = 2'd3
  } cfg_reg_e;

  // Operation codes
  localparam logic OP_REMAP = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Per-word control carried down the divider pipelines
  typedef struct packed {
    logic write_item;
    logic fault;
    logic sat_u;
    logic sat_v;
  } ttcr_ctrl_t;

endpackage

/* rtl/core/ttcr_ram.sv */
module ttcr_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ttcr_div_pipe.sv */
// Restoring divider, one quotient bit per stage. The starting remainder
// must be below the divisor; the divisor must hold while words are in flight.
module ttcr_div_pipe #(
  parameter int N      = 28,
  parameter int DIV_W  = 7,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  in_rem,
  input  logic [N-1:0]      in_dividend,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [DIV_W-1:0]  divisor,
  output logic              out_valid,
  output logic [N-1:0]      out_quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [N];
  logic [DIV_W-1:0]  rem  [N];
  logic [N-1:0]      work [N];
  logic [SIDE_W-1:0] side [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              vld_prev;
    logic [DIV_W-1:0]  rem_prev;
    logic [N-1:0]      work_prev;
    logic [SIDE_W-1:0] side_prev;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;

    if (i == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = in_rem;
      assign work_prev = in_dividend;
      assign side_prev = in_side;
    end else begin : g_rest
      assign vld_prev  = vld[i-1];
      assign rem_prev  = rem[i-1];
      assign work_prev = work[i-1];
      assign side_prev = side[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_prev, work_prev[N-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld_prev;
      end
      rem[i]  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      work[i] <= {work_prev[N-2:0], fits};
      side[i] <= side_prev;
    end
  end

  assign out_valid = vld[N-1];
  assign out_quot  = work[N-1];
  assign out_side  = side[N-1];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rem[N-1] < divisor))
    else $error("divider remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> (divisor != '0))
    else $error("divider fed a zero divisor");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, N))
    else $error("divider output word without matching input");

endmodule

/* rtl/core/texture_tile_coordinate_remap.sv */
// Tile indirection remap. A word is taken at each rising edge with start high
// and busy low, one word per cycle with no gaps; busy is high only during reset
// and the first cycle after it. Every word, remap or table write, gives one result: done is high
// for exactly one cycle, and results leave in the order words came in. The
// receiver cannot hold results off and none is needed. The two dividers give
// one quotient bit per stage: the first splits the table block together with
// the u fraction by blocks_x, the second divides row plus v fraction by
// blocks_y. Table writes and table reads both touch the memory in the same
// pipeline stage, so a remap always sees every earlier write. Table entries
// hold nothing until written; there is no clearing pass. Write the configuration
// registers only while no word is in flight.
module texture_tile_coordinate_remap #(
  parameter int TABLE_DEPTH = ttcr_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = ttcr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [ttcr_pkg::COORD_W-1:0]    coord_u,
  input  logic [ttcr_pkg::COORD_W-1:0]    coord_v,
  input  logic [ttcr_pkg::INDEX_W-1:0]    entry_index,
  input  logic [ttcr_pkg::BLOCK_W-1:0]    entry_block,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [ttcr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ttcr_pkg::CFG_W-1:0]      cfg_data,
  // result channel
  output logic                            done,
  output logic [ttcr_pkg::COORD_W-1:0]    atlas_u,
  output logic [ttcr_pkg::COORD_W-1:0]    atlas_v,
  output logic [ttcr_pkg::BLOCK_W-1:0]    block_number,
  output logic                            fault
);

  localparam int F       = FRAC_BITS;
  localparam int CFG_W   = ttcr_pkg::CFG_W;
  localparam int COORD_W = ttcr_pkg::COORD_W;
  localparam int BLOCK_W = ttcr_pkg::BLOCK_W;
  localparam int INDEX_W = ttcr_pkg::INDEX_W;
  localparam int CELL_W  = ttcr_pkg::CELL_W;
  localparam int LIMIT_W = ttcr_pkg::LIMIT_W;
  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CTRL_W  = $bits(ttcr_pkg::ttcr_ctrl_t);
  localparam int N1      = BLOCK_W + F;   // quotient bits: row above, u fraction below
  localparam int N2      = F;
  localparam int SIDE1_W = CTRL_W + BLOCK_W + F;
  localparam int SIDE2_W = CTRL_W + BLOCK_W + F;
  localparam int LAT     = N1 + N2 + 4;

  localparam logic [LIMIT_W-1:0] DEPTH_LIM = LIMIT_W'(TABLE_DEPTH);
  localparam logic [F-1:0]       FRAC_MAX  = {F{1'b1}};
  localparam logic [F+COORD_W-1:0] SAT_EXT = {{COORD_W{1'b0}}, FRAC_MAX};
  localparam logic [COORD_W-1:0] SAT_OUT   = SAT_EXT[COORD_W-1:0];

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] tiles_x;
  logic [CFG_W-1:0] tiles_y;
  logic [CFG_W-1:0] blocks_x;
  logic [CFG_W-1:0] blocks_y;
  logic [CFG_W-1:0] bx_eff;
  logic [CFG_W-1:0] by_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_x  <= CFG_W'(1);
      tiles_y  <= CFG_W'(1);
      blocks_x <= CFG_W'(1);
      blocks_y <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (ttcr_pkg::cfg_reg_e'(cfg_index))
        ttcr_pkg::REG_TILES_X:  tiles_x  <= cfg_data;
        ttcr_pkg::REG_TILES_Y:  tiles_y  <= cfg_data;
        ttcr_pkg::REG_BLOCKS_X: blocks_x <= cfg_data;
        ttcr_pkg::REG_BLOCKS_Y: blocks_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero atlas size acts as one
  assign bx_eff = (blocks_x == '0) ? CFG_W'(1) : blocks_x;
  assign by_eff = (blocks_y == '0) ? CFG_W'(1) : blocks_y;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the word, keep the low F bits of each coordinate
  // ---------------------------------------------------------------------------
  logic [F+COORD_W-1:0] u_ext;
  logic [F+COORD_W-1:0] v_ext;
  logic                 s1_valid;
  logic                 s1_op;
  logic [F-1:0]         s1_u;
  logic [F-1:0]         s1_v;
  logic [INDEX_W-1:0]   s1_idx;
  logic [BLOCK_W-1:0]   s1_blk;

  assign u_ext = {{F{1'b0}}, coord_u};
  assign v_ext = {{F{1'b0}}, coord_v};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_op  <= operation;
    s1_u   <= u_ext[F-1:0];
    s1_v   <= v_ext[F-1:0];
    s1_idx <= entry_index;
    s1_blk <= entry_block;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale by the tile grid; cell index and table access
  // ---------------------------------------------------------------------------
  logic                   s2_valid;
  logic                   s2_op;
  logic [F+CFG_W-1:0]     s2_su;
  logic [F+CFG_W-1:0]     s2_sv;
  logic [INDEX_W-1:0]     s2_idx;
  logic [BLOCK_W-1:0]     s2_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_op  <= s1_op;
    s2_su  <= {{CFG_W{1'b0}}, s1_u} * {{F{1'b0}}, tiles_x};
    s2_sv  <= {{CFG_W{1'b0}}, s1_v} * {{F{1'b0}}, tiles_y};
    s2_idx <= s1_idx;
    s2_blk <= s1_blk;
  end

  logic [CFG_W-1:0]      cell_x;
  logic [CFG_W-1:0]      cell_y;
  logic [CELL_W-1:0]     cell_idx;
  logic                  cell_ok;
  logic                  widx_ok;
  logic [CELL_W+AW-1:0]  cell_ext;
  logic [INDEX_W+AW-1:0] widx_ext;
  logic                  ram_we;
  logic [BLOCK_W-1:0]    ram_rdata;

  assign cell_x   = s2_su[F+CFG_W-1:F];
  assign cell_y   = s2_sv[F+CFG_W-1:F];
  assign cell_idx = {{(CELL_W-CFG_W){1'b0}}, cell_y} * {{(CELL_W-CFG_W){1'b0}}, tiles_x} +
                    {{(CELL_W-CFG_W){1'b0}}, cell_x};
  assign cell_ok  = (LIMIT_W'(cell_idx) < DEPTH_LIM);
  assign widx_ok  = (LIMIT_W'(s2_idx) < DEPTH_LIM);
  assign cell_ext = {{AW{1'b0}}, cell_idx};
  assign widx_ext = {{AW{1'b0}}, s2_idx};

  // drop writes whose index lies past the table
  assign ram_we = s2_valid && (s2_op == ttcr_pkg::OP_WRITE) && widx_ok;

  ttcr_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_ext[AW-1:0]),
    .wdata (s2_blk),
    .raddr (cell_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: table data back; classify and start the column/row split
  // ---------------------------------------------------------------------------
  logic         s3_valid;
  logic         s3_op;
  logic         s3_cell_ok;
  logic         s3_widx_ok;
  logic [F-1:0] s3_fx;
  logic [F-1:0] s3_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_op      <= s2_op;
    s3_cell_ok <= cell_ok;
    s3_widx_ok <= widx_ok;
    s3_fx      <= s2_su[F-1:0];
    s3_fy      <= s2_sv[F-1:0];
  end

  logic                   read_hit;
  logic [BLOCK_W-1:0]     blk3;
  ttcr_pkg::ttcr_ctrl_t   ctrl1_in;
  logic [SIDE1_W-1:0]     side1_in;

  assign read_hit = (s3_op == ttcr_pkg::OP_REMAP) && s3_cell_ok;
  assign blk3     = read_hit ? ram_rdata : '0;

  always_comb begin
    ctrl1_in.write_item = (s3_op == ttcr_pkg::OP_WRITE);
    ctrl1_in.fault      = (s3_op == ttcr_pkg::OP_WRITE) ? !s3_widx_ok : !s3_cell_ok;
    ctrl1_in.sat_u      = (s3_op == ttcr_pkg::OP_REMAP) && !s3_cell_ok;
    ctrl1_in.sat_v      = (s3_op == ttcr_pkg::OP_REMAP) && !s3_cell_ok;
  end

  assign side1_in = {ctrl1_in, blk3, s3_fy};

  // (block * 2^F + fx) / bx gives row in the upper bits and atlas_u below
  logic               d1_valid;
  logic [N1-1:0]      d1_quot;
  logic [SIDE1_W-1:0] d1_side;

  ttcr_div_pipe #(
    .N      (N1),
    .DIV_W  (CFG_W),
    .SIDE_W (SIDE1_W)
  ) u_div_col (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s3_valid),
    .in_rem      ('0),
    .in_dividend ({blk3, s3_fx}),
    .in_side     (side1_in),
    .divisor     (bx_eff),
    .out_valid   (d1_valid),
    .out_quot    (d1_quot),
    .out_side    (d1_side)
  );

  // ---------------------------------------------------------------------------
  // Row check, then (row * 2^F + fy) / by
  // ---------------------------------------------------------------------------
  ttcr_pkg::ttcr_ctrl_t ctrl1_out;
  ttcr_pkg::ttcr_ctrl_t ctrl2_in;
  logic [BLOCK_W-1:0]   blk1_out;
  logic [F-1:0]         fy1_out;
  logic [BLOCK_W-1:0]   row;
  logic [F-1:0]         au1;
  logic                 row_bad;
  logic [CFG_W-1:0]     row_rem;
  logic [SIDE2_W-1:0]   side2_in;

  assign ctrl1_out = ttcr_pkg::ttcr_ctrl_t'(d1_side[SIDE1_W-1 -: CTRL_W]);
  assign blk1_out  = d1_side[F +: BLOCK_W];
  assign fy1_out   = d1_side[F-1:0];
  assign row       = d1_quot[N1-1:F];
  assign au1       = d1_quot[F-1:0];
  assign row_bad   = !ctrl1_out.write_item && !ctrl1_out.sat_u &&
                     (row >= {{(BLOCK_W-CFG_W){1'b0}}, by_eff});
  // hold the divider remainder below the divisor on a bad row
  assign row_rem   = row_bad ? '0 : row[CFG_W-1:0];

  always_comb begin
    ctrl2_in       = ctrl1_out;
    ctrl2_in.fault = ctrl1_out.fault || row_bad;
    ctrl2_in.sat_v = ctrl1_out.sat_v || row_bad;
  end

  assign side2_in = {ctrl2_in, blk1_out, au1};

  logic               d2_valid;
  logic [N2-1:0]      d2_quot;
  logic [SIDE2_W-1:0] d2_side;

  ttcr_div_pipe #(
    .N      (N2),
    .DIV_W  (CFG_W),
    .SIDE_W (SIDE2_W)
  ) u_div_row (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d1_valid),
    .in_rem      (row_rem),
    .in_dividend (fy1_out),
    .in_side     (side2_in),
    .divisor     (by_eff),
    .out_valid   (d2_valid),
    .out_quot    (d2_quot),
    .out_side    (d2_side)
  );

  // ---------------------------------------------------------------------------
  // Output register: saturate, zero write results, fit to the port width
  // ---------------------------------------------------------------------------
  ttcr_pkg::ttcr_ctrl_t ctrl2_out;
  logic [BLOCK_W-1:0]   blk2_out;
  logic [F-1:0]         au2_out;
  logic [F-1:0]         u_final;
  logic [F-1:0]         v_final;
  logic [F+COORD_W-1:0] u_final_ext;
  logic [F+COORD_W-1:0] v_final_ext;

  assign ctrl2_out = ttcr_pkg::ttcr_ctrl_t'(d2_side[SIDE2_W-1 -: CTRL_W]);
  assign blk2_out  = d2_side[F +: BLOCK_W];
  assign au2_out   = d2_side[F-1:0];

  always_comb begin
    if (ctrl2_out.write_item) begin
      u_final = '0;
      v_final = '0;
    end else begin
      u_final = ctrl2_out.sat_u ? FRAC_MAX : au2_out;
      v_final = ctrl2_out.sat_v ? FRAC_MAX : d2_quot;
    end
  end

  assign u_final_ext = {{COORD_W{1'b0}}, u_final};
  assign v_final_ext = {{COORD_W{1'b0}}, v_final};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_valid;
    end
    atlas_u      <= u_final_ext[COORD_W-1:0];
    atlas_v      <= v_final_ext[COORD_W-1:0];
    block_number <= ctrl2_out.write_item ? '0 : blk2_out;
    fault        <= ctrl2_out.fault;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result word without an accepted command word");

  a_row_fault_saturates: assert property (@(posedge clk) disable iff (rst)
    (done && fault && (block_number != '0)) |-> (atlas_v == SAT_OUT))
    else $error("row fault without saturated atlas_v");

  a_fault_both_axes: assert property (@(posedge clk) disable iff (rst)
    (done && fault && (block_number == '0)) |-> (atlas_u == atlas_v))
    else $error("index fault with mismatched coordinates");

endmodule

/* verif/ttcr_remap_checker.sv */
`timescale 1ns / 1ps

module ttcr_remap_checker
  import ttcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 operation,
  input  logic [COORD_W-1:0]   coord_u,
  input  logic [COORD_W-1:0]   coord_v,
  input  logic [INDEX_W-1:0]   entry_index,
  input  logic [BLOCK_W-1:0]   entry_block,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 done,
  input  logic [COORD_W-1:0]   atlas_u,
  input  logic [COORD_W-1:0]   atlas_v,
  input  logic [BLOCK_W-1:0]   block_number,
  input  logic                 fault,
  output int                   mismatch_count,
  output int                   words_in_flight
);

  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct packed {
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic [BLOCK_W-1:0] blk;
    logic               flt;
  } atlas_word_t;

  logic [CFG_W-1:0]   tiles_x_q;
  logic [CFG_W-1:0]   tiles_y_q;
  logic [CFG_W-1:0]   blocks_x_q;
  logic [CFG_W-1:0]   blocks_y_q;
  logic [BLOCK_W-1:0] block_store [DEPTH];
  atlas_word_t        pending_atlas_q [$];
  int                 errs;

  // Scale by the tile grid, look the cell up and place it in the atlas.
  function automatic atlas_word_t remap_coordinate(logic [COORD_W-1:0] u,
                                                   logic [COORD_W-1:0] v);
    atlas_word_t r;
    logic [COORD_W+CFG_W-1:0] scaled_u;
    logic [COORD_W+CFG_W-1:0] scaled_v;
    int unsigned cell_idx;
    int unsigned bx;
    int unsigned by;
    int unsigned col;
    int unsigned row;
    scaled_u = {{CFG_W{1'b0}}, u} * {{COORD_W{1'b0}}, tiles_x_q};
    scaled_v = {{CFG_W{1'b0}}, v} * {{COORD_W{1'b0}}, tiles_y_q};
    cell_idx = scaled_v[COORD_W +: CFG_W] * tiles_x_q + scaled_u[COORD_W +: CFG_W];
    bx = (blocks_x_q == 0) ? 1 : blocks_x_q;
    by = (blocks_y_q == 0) ? 1 : blocks_y_q;
    r = '0;
    if (cell_idx >= DEPTH) begin
      r.flt = 1'b1;
      r.u = '1;
      r.v = '1;
    end else begin
      r.blk = block_store[cell_idx];
      col = r.blk % bx;
      row = r.blk / bx;
      r.u = COORD_W'(((col << COORD_W) + scaled_u[COORD_W-1:0]) / bx);
      if (row >= by) begin
        r.flt = 1'b1;
        r.v = '1;
      end else begin
        r.v = COORD_W'(((row << COORD_W) + scaled_v[COORD_W-1:0]) / by);
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [COORD_W-1:0] want,
                             logic [COORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    atlas_word_t want;
    if (rst) begin
      tiles_x_q  <= CFG_W'(1);
      tiles_y_q  <= CFG_W'(1);
      blocks_x_q <= CFG_W'(1);
      blocks_y_q <= CFG_W'(1);
      pending_atlas_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TILES_X:  tiles_x_q  <= cfg_data;
          REG_TILES_Y:  tiles_y_q  <= cfg_data;
          REG_BLOCKS_X: blocks_x_q <= cfg_data;
          REG_BLOCKS_Y: blocks_y_q <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (operation == OP_WRITE) begin
          want = '0;
          if (entry_index < DEPTH) block_store[entry_index] = entry_block;
          else want.flt = 1'b1;
        end else begin
          want = remap_coordinate(coord_u, coord_v);
        end
        pending_atlas_q = {pending_atlas_q, want};
      end
      if (done) begin
        if (pending_atlas_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual u=%h v=%h blk=%h fault=%b",
                   $time, atlas_u, atlas_v, block_number, fault);
          errs++;
        end else begin
          want = pending_atlas_q.pop_front();
          check_field("atlas_u", want.u, atlas_u);
          check_field("atlas_v", want.v, atlas_v);
          check_field("block_number", COORD_W'(want.blk), COORD_W'(block_number));
          check_field("fault", COORD_W'(want.flt), COORD_W'(fault));
        end
      end
    end
    words_in_flight <= pending_atlas_q.size();
    mismatch_count  <= errs;
  end

endmodule

/* verif/tb_texture_tile_coordinate_remap.sv */
`timescale 1ns / 1ps

module tb_texture_tile_coordinate_remap;
  import ttcr_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int PHASE_WORDS  = 56;      // random words per configuration phase
  localparam int SETTLE       = 2 * FRAC_BITS_DEF + 32;
  localparam int CYCLE_LIMIT  = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 operation = OP_REMAP;
  logic [COORD_W-1:0]   coord_u = '0;
  logic [COORD_W-1:0]   coord_v = '0;
  logic [INDEX_W-1:0]   entry_index = '0;
  logic [BLOCK_W-1:0]   entry_block = '0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 done;
  logic [COORD_W-1:0]   atlas_u;
  logic [COORD_W-1:0]   atlas_v;
  logic [BLOCK_W-1:0]   block_number;
  logic                 fault;
  int                   mismatch_count;
  int                   words_in_flight;
  int                   cycle_count;

  // Shadow of the register settings, used only to find the cell a coordinate hits and to pick blocks.
  logic [CFG_W-1:0] cur_tiles_x = CFG_W'(1);
  logic [CFG_W-1:0] cur_tiles_y = CFG_W'(1);
  logic [CFG_W-1:0] cur_blocks_x = CFG_W'(1);
  logic [CFG_W-1:0] cur_blocks_y = CFG_W'(1);
  // Cells written so far; a remap never lands on a cell still missing here.
  bit written_cell [DEPTH];
  int burst_left = 0;
  bit gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  texture_tile_coordinate_remap uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .coord_u      (coord_u),
    .coord_v      (coord_v),
    .entry_index  (entry_index),
    .entry_block  (entry_block),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .atlas_u      (atlas_u),
    .atlas_v      (atlas_v),
    .block_number (block_number),
    .fault        (fault)
  );

  ttcr_remap_checker remap_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .coord_u         (coord_u),
    .coord_v         (coord_v),
    .entry_index     (entry_index),
    .entry_block     (entry_block),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .atlas_u         (atlas_u),
    .atlas_v         (atlas_v),
    .block_number    (block_number),
    .fault           (fault),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  // Count cycles and stop a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d words still in flight",
             $time, cycle_count, words_in_flight);
    $display("tb_texture_tile_coordinate_remap: FAIL");
    $finish;
  end

  // Mostly raw random, with the two extremes showing up often.
  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COORD_W'($urandom_range(0, 65535));
  endfunction

  // Cell hit by (u, v) under the current tile grid, row major.
  function automatic int unsigned cell_of(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int unsigned cx;
    int unsigned cy;
    cx = (int'(u) * cur_tiles_x) >> COORD_W;
    cy = (int'(v) * cur_tiles_y) >> COORD_W;
    return cy * cur_tiles_x + cx;
  endfunction

  // Favor blocks that fall inside the atlas so the row check mostly passes;
  // keep some past the last row and some fully random.
  function automatic logic [BLOCK_W-1:0] pick_block();
    int unsigned bx;
    int unsigned by;
    int unsigned span;
    int unsigned r;
    int unsigned b;
    bx = (cur_blocks_x == 0) ? 1 : cur_blocks_x;
    by = (cur_blocks_y == 0) ? 1 : cur_blocks_y;
    span = bx * by;
    r = $urandom_range(0, 9);
    if (r < 7) b = (span > DEPTH) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, span - 1);
    else if (r < 9) b = $urandom_range(0, 4095);
    else b = span + $urandom_range(0, bx);
    if (b > 4095) b = 4095;
    return BLOCK_W'(b);
  endfunction

  // When gaps are on, hold start low for a random gap at the end of each burst.
  task automatic pace_sender();
    if (burst_left == 0) begin
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Present one word and hold it until the edge that takes it. Leave start
  // high on return so back-to-back words keep the channel full.
  task automatic send_word(logic op, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                           logic [INDEX_W-1:0] idx, logic [BLOCK_W-1:0] blk);
    pace_sender();
    start       <= 1'b1;
    operation   <= op;
    coord_u     <= u;
    coord_v     <= v;
    entry_index <= idx;
    entry_block <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE && idx < DEPTH) written_cell[idx] = 1'b1;
  endtask

  task automatic write_entry(logic [INDEX_W-1:0] idx, logic [BLOCK_W-1:0] blk);
    send_word(OP_WRITE, rand_coord(), rand_coord(), idx, blk);
  endtask

  // Fill the target cell first when it was never written, then remap.
  task automatic remap_word(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int unsigned tgt_cell;
    tgt_cell = cell_of(u, v);
    if (tgt_cell < DEPTH && !written_cell[tgt_cell]) write_entry(INDEX_W'(tgt_cell), pick_block());
    send_word(OP_REMAP, u, v, INDEX_W'($urandom_range(0, 4095)),
              BLOCK_W'($urandom_range(0, 4095)));
  endtask

  // Drop start and wait until every result word has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic set_grid(int unsigned tx, int unsigned ty, int unsigned bx, int unsigned by);
    drain();
    write_reg(REG_TILES_X, CFG_W'(tx));
    write_reg(REG_TILES_Y, CFG_W'(ty));
    write_reg(REG_BLOCKS_X, CFG_W'(bx));
    write_reg(REG_BLOCKS_Y, CFG_W'(by));
    cfg_we <= 1'b0;
    cur_tiles_x  = CFG_W'(tx);
    cur_tiles_y  = CFG_W'(ty);
    cur_blocks_x = CFG_W'(bx);
    cur_blocks_y = CFG_W'(by);
  endtask

  // Grid settings for the random phases: the extremes, zero sizes, a few
  // lopsided ones; the last four are drawn at random.
  int unsigned grid_set [12][4] = '{
    '{1, 1, 1, 1}, '{64, 64, 64, 64}, '{8, 8, 16, 16}, '{127, 127, 1, 127},
    '{0, 5, 0, 3}, '{3, 0, 64, 1}, '{64, 64, 127, 127}, '{16, 2, 5, 7},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}
  };

  initial begin
    int unsigned r;
    int unsigned pause_at;
    int unsigned tgt_cell;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: reset grid of one tile and one block, both coordinate extremes.
    gaps_on = 1'b0;
    write_entry(12'd0, 12'd0);
    remap_word(16'h0000, 16'h0000);
    remap_word(16'hFFFF, 16'hFFFF);

    // 4x4 tiles over an 8x8 atlas: last block in range, first block past the
    // last row, the top table index, and a mid cell with mixed bits.
    set_grid(4, 4, 8, 8);
    write_entry(12'd5, 12'd63);
    write_entry(12'd15, 12'd64);
    write_entry(12'hFFF, 12'hFFF);
    write_entry(12'd9, 12'h5A5);
    remap_word(16'h4000, 16'h4000);
    remap_word(16'hFFFF, 16'hFFFF);
    remap_word(16'h7FFF, 16'hBFFF);
    remap_word(16'h0000, 16'h0000);

    // Zero tile and atlas sizes: every remap lands on cell 0, atlas sizes act as one.
    set_grid(0, 0, 0, 0);
    write_entry(12'd0, 12'd1);
    remap_word(16'h1234, 16'hABCD);
    write_entry(12'd0, 12'd0);
    remap_word(16'hFFFF, 16'hFFFF);

    // Widest register values: far corner cell lies past the end of the table.
    set_grid(127, 127, 127, 127);
    remap_word(16'hFFFF, 16'hFFFF);
    remap_word(16'h0000, 16'h0000);
    write_entry(12'd0, 12'hFFF);
    remap_word(16'h0000, 16'h0000);
    remap_word(16'h0100, 16'hFF00);

    // Random phases: mostly remaps, table writes in between, and now and then
    // a rewrite of a cell right before it is read back.
    for (int p = 0; p < 12; p++) begin
      if (p >= 8) begin
        for (int k = 0; k < 4; k++) grid_set[p][k] = $urandom_range(0, 127);
      end
      set_grid(grid_set[p][0], grid_set[p][1], grid_set[p][2], grid_set[p][3]);
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      pause_at = $urandom_range(10, PHASE_WORDS - 10);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Stall the sender until the pipeline runs dry once per phase.
        if (n == pause_at) drain();
        r = $urandom_range(0, 99);
        u = rand_coord();
        v = rand_coord();
        if (r < 65) begin
          remap_word(u, v);
        end else if (r < 90) begin
          write_entry(INDEX_W'($urandom_range(0, 4095)), pick_block());
        end else begin
          tgt_cell = cell_of(u, v);
          if (tgt_cell < DEPTH) write_entry(INDEX_W'(tgt_cell), pick_block());
          remap_word(u, v);
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_texture_tile_coordinate_remap: PASS");
    end else begin
      $display("tb_texture_tile_coordinate_remap: FAIL");
    end
    $finish;
  end

endmodule
